>>> rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// Contained rectangle suppression package
// Shared rectangle types, the cell link type, the controller states and the
// containment test used by every cell of the chain.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SPAN_W  = 13;
  // Right or bottom edge: coordinate plus span, no wrap.
  localparam int unsigned EDGE_W  = 14;

  typedef struct packed {
    logic [SPAN_W-1:0]  span_y;
    logic [SPAN_W-1:0]  span_x;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } rect_t;

  // What one cell hands to its neighbor.
  typedef struct packed {
    rect_t rect;
    logic  valid;
    logic  covered;
  } link_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // True when rectangle a lies inside rectangle b.
  function automatic logic rect_inside(rect_t a, rect_t b);
    logic [EDGE_W-1:0] a_right;
    logic [EDGE_W-1:0] a_bottom;
    logic [EDGE_W-1:0] b_right;
    logic [EDGE_W-1:0] b_bottom;
    a_right  = EDGE_W'(a.left) + EDGE_W'(a.span_x);
    a_bottom = EDGE_W'(a.top)  + EDGE_W'(a.span_y);
    b_right  = EDGE_W'(b.left) + EDGE_W'(b.span_x);
    b_bottom = EDGE_W'(b.top)  + EDGE_W'(b.span_y);
    return (a.left >= b.left) && (a.top >= b.top) &&
           (a_right <= b_right) && (a_bottom <= b_bottom);
  endfunction

endpackage

>>> rtl/crs_cell.sv
// ----------------------------------------------------------------------------
// Contained rectangle suppression cell
// Holds one rectangle and its covered flag, compares it against the rectangle
// being loaded, and shifts its contents to the next cell on command.
// ----------------------------------------------------------------------------
module crs_cell
  import crs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  logic  cmp_en,
  input  rect_t new_rect,
  input  link_t link_in,
  output link_t link_out,
  output logic  new_in_me
);

  rect_t rect_r;
  logic  valid_r;
  logic  covered_r;
  logic  differs;
  logic  me_in_new;

  // Compare the stored rectangle with the one arriving. Identical copies
  // never cover each other.
  assign differs   = (rect_r != new_rect);
  assign me_in_new = valid_r && differs && rect_inside(rect_r, new_rect);
  assign new_in_me = valid_r && differs && rect_inside(new_rect, rect_r);

  // The flag passed on already includes the hit from the arriving rectangle.
  assign link_out.rect    = rect_r;
  assign link_out.valid   = valid_r;
  assign link_out.covered = covered_r || (cmp_en && me_in_new);

  // Control bits of the cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      covered_r <= 1'b0;
    end else if (shift_en) begin
      valid_r   <= link_in.valid;
      covered_r <= link_in.covered;
    end
  end

  // Stored rectangle.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rect_r <= link_in.rect;
    end
  end

endmodule

>>> rtl/contained_rect_suppression_top.sv
// ----------------------------------------------------------------------------
// Contained rectangle suppression, top level
// Collects a set of rectangles in a chain of cells and emits, in arrival order,
// every rectangle that does not lie inside another, different one of the set.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry one rectangle each; in_set_end marks
//   the last rectangle of a set. While a set loads, one beat is taken per
//   cycle: each arriving rectangle is compared against all stored cells at
//   once and then shifted into the head of the chain.
//   After the beat with in_set_end, in_ready stays low while the chain shifts
//   toward its tail, one cell per cycle while the output register can take a
//   result. Each surviving rectangle reaching the tail is placed in the output
//   register; out_end marks the last survivor. Emission shifts every cell out
//   of the chain (empty cells pass as bubbles). in_ready returns once the
//   controller has seen the chain drained and gone back to loading.
//   When the receiver stalls, the chain holds still and no result is lost.
//   Rectangles beyond MAX_RECTS in one set are dropped; their set_end flag is
//   still honored. Reset empties the chain and drops any pending result.
// ----------------------------------------------------------------------------
module contained_rect_suppression_top
  import crs_pkg::*;
#(
  parameter int unsigned MAX_RECTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COORD_W-1:0]  in_left,
  input  logic [COORD_W-1:0]  in_top,
  input  logic [SPAN_W-1:0]   in_span_x,
  input  logic [SPAN_W-1:0]   in_span_y,
  input  logic                in_set_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_left,
  output logic [COORD_W-1:0]  out_top,
  output logic [SPAN_W-1:0]   out_span_x,
  output logic [SPAN_W-1:0]   out_span_y,
  output logic                out_end
);

  localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  rect_t               out_rect_r, out_rect_nxt;
  logic                out_end_r, out_end_nxt;

  rect_t               new_rect;
  link_t               links [MAX_RECTS+1];
  logic [MAX_RECTS-1:0] new_in_vec;
  logic [MAX_RECTS-1:0] valid_vec;
  logic                full;
  logic                load_en;
  logic                shift_en;
  logic                advance;
  logic                tail_hit;
  logic                survivor_below;

  assign new_rect = '{span_y: in_span_y, span_x: in_span_x, top: in_top, left: in_left};
  assign full     = (count_r == CNT_W'(MAX_RECTS));

  // Head of the chain: the arriving rectangle while loading, bubbles while
  // draining.
  assign links[0].rect    = new_rect;
  assign links[0].valid   = (state_r == ST_LOAD);
  assign links[0].covered = |new_in_vec;

  // Row of cells.
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    crs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .cmp_en    (load_en),
      .new_rect  (new_rect),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .new_in_me (new_in_vec[i])
    );
    assign valid_vec[i] = links[i+1].valid;
  end

  // Any survivor still behind the tail cell.
  always_comb begin
    survivor_below = 1'b0;
    for (int i = 1; i < MAX_RECTS; i++) begin
      survivor_below = survivor_below || (links[i].valid && !links[i].covered);
    end
  end

  assign tail_hit = links[MAX_RECTS].valid && !links[MAX_RECTS].covered;

  // Controller: next state, chain control and output register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rect_nxt  = out_rect_r;
    out_end_nxt   = out_end_r;
    in_ready      = 1'b0;
    load_en       = 1'b0;
    advance       = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load_en = !full;
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_set_end) begin
            state_nxt = ST_EMIT;
            count_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (!(|valid_vec)) begin
          state_nxt = ST_LOAD;
        end else begin
          advance = !out_valid_r || out_ready;
          if (advance && tail_hit) begin
            out_valid_nxt = 1'b1;
            out_rect_nxt  = links[MAX_RECTS].rect;
            out_end_nxt   = !survivor_below;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign shift_en = load_en || advance;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_rect_r <= out_rect_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_left   = out_rect_r.left;
  assign out_top    = out_rect_r.top;
  assign out_span_x = out_rect_r.span_x;
  assign out_span_y = out_rect_r.span_y;
  assign out_end    = out_end_r;

endmodule

>>> tb/sv/contained_rect_suppression_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Contained rectangle suppression testbench
// Sends sets of rectangles: first a short directed table, then random sets
// built to nest, repeat and enclose each other, under several idling phases.
// A behavioral predictor works out the survivors of every set, and each
// output beat is checked field by field against the oldest expected survivor.
// ----------------------------------------------------------------------------
module contained_rect_suppression_top_test;
  import crs_pkg::*;

  localparam int unsigned MAX_RECTS    = 64;
  localparam int unsigned COORD_MAX    = 4095;
  localparam int unsigned SPAN_MAX     = 4096;
  localparam int unsigned NUM_DIRECTED = 23;
  localparam int unsigned RANDOM_ITEMS = 437;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_RECTS;

  // Idle and stall rates in percent for each phase of the random part.
  localparam int unsigned SEND_IDLE [NUM_PHASES] = '{0, 62, 0, 17};
  localparam int unsigned RECV_STALL[NUM_PHASES] = '{0, 0, 62, 17};

  // How a random rectangle relates to one already in its set.
  typedef enum int {
    PICK_FRESH,
    PICK_INSIDE,
    PICK_SAME,
    PICK_AROUND
  } pick_t;

  // One row of the directed table. With echo set, the row is a set of its
  // own and the rectangle is expected back unchanged as the last survivor.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SPAN_W-1:0]  span_x;
    logic [SPAN_W-1:0]  span_y;
    logic               set_end;
    logic               echo;
  } dir_row_t;

  typedef struct packed {
    rect_t rect;
    logic  last;
  } survivor_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] in_left    = '0;
  logic [COORD_W-1:0] in_top     = '0;
  logic [SPAN_W-1:0]  in_span_x  = SPAN_W'(1);
  logic [SPAN_W-1:0]  in_span_y  = SPAN_W'(1);
  logic               in_set_end = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_top;
  logic [SPAN_W-1:0]  out_span_x;
  logic [SPAN_W-1:0]  out_span_y;
  logic               out_end;

  rect_t       open_set[$];
  survivor_t   survivors_due[$];
  int unsigned errors     = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned quiet      = 0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // Lone rectangles right after reset: smallest, largest, all low span bits.
    '{12'd0,    12'd0,    13'd1,    13'd1,    1'b1, 1'b1},
    '{12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1, 1'b1},
    '{12'd1,    12'd1,    13'd4095, 13'd4095, 1'b1, 1'b1},
    // Outer rectangle first, then one inside it.
    '{12'd0,    12'd0,    13'd100,  13'd100,  1'b0, 1'b0},
    '{12'd10,   12'd10,   13'd20,   13'd20,   1'b1, 1'b0},
    // Inner rectangle first.
    '{12'd10,   12'd10,   13'd20,   13'd20,   1'b0, 1'b0},
    '{12'd0,    12'd0,    13'd100,  13'd100,  1'b1, 1'b0},
    // Identical duplicates are both kept.
    '{12'd5,    12'd5,    13'd10,   13'd10,   1'b0, 1'b0},
    '{12'd5,    12'd5,    13'd10,   13'd10,   1'b1, 1'b0},
    // Shared corner, shorter height.
    '{12'd0,    12'd0,    13'd50,   13'd50,   1'b0, 1'b0},
    '{12'd0,    12'd0,    13'd50,   13'd40,   1'b1, 1'b0},
    // Disjoint rectangles.
    '{12'd0,    12'd0,    13'd10,   13'd10,   1'b0, 1'b0},
    '{12'd20,   12'd20,   13'd10,   13'd10,   1'b1, 1'b0},
    // Partial overlap.
    '{12'd0,    12'd0,    13'd10,   13'd10,   1'b0, 1'b0},
    '{12'd5,    12'd5,    13'd10,   13'd10,   1'b1, 1'b0},
    // Edges far past the coordinate range must not wrap.
    '{12'd4000, 12'd4000, 13'd4096, 13'd4096, 1'b0, 1'b0},
    '{12'd4095, 12'd4095, 13'd1,    13'd1,    1'b1, 1'b0},
    // Duplicates that both lie inside a third rectangle.
    '{12'd0,    12'd0,    13'd100,  13'd100,  1'b0, 1'b0},
    '{12'd10,   12'd10,   13'd5,    13'd5,    1'b0, 1'b0},
    '{12'd10,   12'd10,   13'd5,    13'd5,    1'b1, 1'b0},
    // Three nested rectangles.
    '{12'd0,    12'd0,    13'd30,   13'd30,   1'b0, 1'b0},
    '{12'd1,    12'd1,    13'd20,   13'd20,   1'b0, 1'b0},
    '{12'd2,    12'd2,    13'd10,   13'd10,   1'b1, 1'b0}
  };

  contained_rect_suppression_top #(
    .MAX_RECTS(MAX_RECTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_left   (in_left),
    .in_top    (in_top),
    .in_span_x (in_span_x),
    .in_span_y (in_span_y),
    .in_set_end(in_set_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left),
    .out_top   (out_top),
    .out_span_x(out_span_x),
    .out_span_y(out_span_y),
    .out_end   (out_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // True when rectangle a lies inside rectangle b, edges at full width.
  function automatic bit lies_within(rect_t a, rect_t b);
    int unsigned a_right;
    int unsigned a_bottom;
    int unsigned b_right;
    int unsigned b_bottom;
    a_right  = int'(a.left) + int'(a.span_x);
    a_bottom = int'(a.top) + int'(a.span_y);
    b_right  = int'(b.left) + int'(b.span_x);
    b_bottom = int'(b.top) + int'(b.span_y);
    return (a.left >= b.left) && (a.top >= b.top) &&
           (a_right <= b_right) && (a_bottom <= b_bottom);
  endfunction

  // Stores an accepted rectangle; on the set's last beat, queues the survivors.
  function automatic void absorb_rect(rect_t r, logic set_end);
    bit        covered[MAX_RECTS];
    int        last_kept;
    survivor_t s;
    if (open_set.size() < MAX_RECTS) open_set = {open_set, r};
    if (!set_end) return;
    last_kept = -1;
    foreach (open_set[i]) begin
      covered[i] = 1'b0;
      foreach (open_set[j]) begin
        if (open_set[j] != open_set[i] && lies_within(open_set[i], open_set[j]))
          covered[i] = 1'b1;
      end
      if (!covered[i]) last_kept = i;
    end
    foreach (open_set[i]) begin
      if (!covered[i]) begin
        s.rect = open_set[i];
        s.last = (i == last_kept);
        survivors_due = {survivors_due, s};
      end
    end
    open_set.delete();
  endfunction

  // Random span: mostly scaled to the set's reach, sometimes the full range.
  function automatic int unsigned draw_span(int unsigned reach);
    case ($urandom_range(7))
      0: return SPAN_MAX;
      1: return $urandom_range(1, SPAN_MAX);
      default: return $urandom_range(1, reach / 2 + 1);
    endcase
  endfunction

  // Picks one axis of a rectangle inside or around the span b_pos..b_pos+b_len.
  function automatic void nest_axis(pick_t how, int unsigned b_pos, int unsigned b_len,
                                    output int unsigned pos, output int unsigned len);
    int unsigned b_end;
    int unsigned lo;
    int unsigned need;
    b_end = b_pos + b_len;
    if (how == PICK_INSIDE) begin
      pos = $urandom_range(b_pos, (b_end - 1 > COORD_MAX) ? COORD_MAX : b_end - 1);
      len = $urandom_range(1, b_end - pos);
    end else begin
      lo   = (b_end > SPAN_MAX) ? b_end - SPAN_MAX : 0;
      pos  = $urandom_range(lo, b_pos);
      need = b_end - pos;
      len  = $urandom_range(need, (need + 16 > SPAN_MAX) ? SPAN_MAX : need + 16);
    end
  endfunction

  // Drives one rectangle beat after an optional idle gap and waits for it
  // to be taken; the prediction is updated at the accepting edge.
  task automatic send_rect(rect_t r, logic set_end, logic echo);
    int unsigned gap;
    survivor_t   s;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_left    <= r.left;
    in_top     <= r.top;
    in_span_x  <= r.span_x;
    in_span_y  <= r.span_y;
    in_set_end <= set_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (echo) begin
      s.rect = r;
      s.last = 1'b1;
      survivors_due = {survivors_due, s};
    end else begin
      absorb_rect(r, set_end);
    end
    items_sent++;
  endtask

  // Sends a random set whose members often nest in, repeat or enclose
  // earlier members.
  task automatic send_random_set(int unsigned count);
    rect_t       members[$];
    rect_t       r;
    rect_t       b;
    pick_t       how;
    int unsigned reach;
    int unsigned pos;
    int unsigned len;
    reach = ($urandom_range(3) == 0) ? COORD_MAX : 63;
    for (int unsigned k = 0; k < count; k++) begin
      how = (members.size() == 0) ? PICK_FRESH : pick_t'($urandom_range(PICK_AROUND));
      if (members.size() != 0) b = members[$urandom_range(members.size() - 1)];
      case (how)
        PICK_FRESH: begin
          r.left   = COORD_W'($urandom_range(reach));
          r.top    = COORD_W'($urandom_range(reach));
          r.span_x = SPAN_W'(draw_span(reach));
          r.span_y = SPAN_W'(draw_span(reach));
        end
        PICK_SAME: begin
          r = b;
        end
        default: begin
          nest_axis(how, 32'(b.left), 32'(b.span_x), pos, len);
          r.left   = COORD_W'(pos);
          r.span_x = SPAN_W'(len);
          nest_axis(how, 32'(b.top), 32'(b.span_y), pos, len);
          r.top    = COORD_W'(pos);
          r.span_y = SPAN_W'(len);
        end
      endcase
      members = {members, r};
      send_rect(r, k == count - 1, 1'b0);
    end
  endtask

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every output beat against the oldest expected survivor.
  always @(posedge clk) begin : check_results
    survivor_t due;
    if (rst_n && out_valid && out_ready) begin
      if (survivors_due.size() == 0) begin
        $display("%0t: unexpected beat: left %0d top %0d span %0d x %0d end %0b",
                 $time, out_left, out_top, out_span_x, out_span_y, out_end);
        errors++;
      end else begin
        due = survivors_due.pop_front();
        if (out_left !== due.rect.left) begin
          $display("%0t: out_left expected %0d, got %0d", $time, due.rect.left, out_left);
          errors++;
        end
        if (out_top !== due.rect.top) begin
          $display("%0t: out_top expected %0d, got %0d", $time, due.rect.top, out_top);
          errors++;
        end
        if (out_span_x !== due.rect.span_x) begin
          $display("%0t: out_span_x expected %0d, got %0d",
                   $time, due.rect.span_x, out_span_x);
          errors++;
        end
        if (out_span_y !== due.rect.span_y) begin
          $display("%0t: out_span_y expected %0d, got %0d",
                   $time, due.rect.span_y, out_span_y);
          errors++;
        end
        if (out_end !== due.last) begin
          $display("%0t: out_end expected %0b, got %0b", $time, due.last, out_end);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    rect_t       r;
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r.left   = directed_rows[i].left;
      r.top    = directed_rows[i].top;
      r.span_x = directed_rows[i].span_x;
      r.span_y = directed_rows[i].span_y;
      send_rect(r, directed_rows[i].set_end, directed_rows[i].echo);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Hold the sender off until every expected survivor has come out.
      in_valid <= 1'b0;
      while (survivors_due.size() != 0) @(negedge clk);
      idle_pct  = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      @(posedge clk);
      // One set that fills the store exactly, and one that overflows it.
      if (p == 0) send_random_set(MAX_RECTS);
      if (p == 2) send_random_set(MAX_RECTS + $urandom_range(1, 4));
      target = NUM_DIRECTED + (p + 1) * RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        send_random_set(($urandom_range(4) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8));
      end
    end

    in_valid <= 1'b0;
    while (survivors_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
